>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the ARQ sender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising edge of aclk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks that two conditions never hold in the same cycle.
`define ASSERT_NEVER_BOTH(label, a, b, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !((a) && (b))) \
        else $error(msg);

`endif

>>> hdl/arqsw_pkg.sv
// Package with the types, codes and constants of the ARQ sender.
`default_nettype none
package arqsw_pkg;

    localparam int SEQ_COUNT_DEF = 8;
    localparam int MAX_RESULTS   = 7;
    localparam int CMP_W         = 9;
    localparam int CNT_W         = 3;
    localparam int WIN_W         = 3;
    localparam int SEQ_FIELD_W   = 3;
    localparam int REQ_W         = 2;
    localparam int KIND_W        = 2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 3'd4;

    localparam logic [REQ_W-1:0] REQ_NEW     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic produces;
        logic last;
    } sts_t;

endpackage
`default_nettype wire

>>> hdl/arqsw_ctrl.sv
// Controller state machine that sequences item intake and result transfers.
`default_nettype none
module arqsw_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire arqsw_pkg::sts_t sts,
    output arqsw_pkg::cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_OUT  = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (sts.produces) begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (sts.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/arqsw_dpath.sv
// Datapath holding the window state, the timeout run counters and the result register.
`default_nettype none
module arqsw_dpath #(
    parameter int SEQ_COUNT = arqsw_pkg::SEQ_COUNT_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_write,
    input  wire logic [arqsw_pkg::WIN_W-1:0]         cfg_window_size,
    input  wire logic [arqsw_pkg::REQ_W-1:0]         s_req_type,
    input  wire logic [arqsw_pkg::SEQ_FIELD_W-1:0]   s_ack_seq,
    input  wire logic                                s_ack_error,
    input  wire arqsw_pkg::cmd_t                     cmd,
    output arqsw_pkg::sts_t                          sts,
    output logic [arqsw_pkg::KIND_W-1:0]             m_kind,
    output logic [arqsw_pkg::SEQ_FIELD_W-1:0]        m_seq,
    output logic                                     m_last
);

    localparam int SW = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
    localparam int CW = arqsw_pkg::CMP_W;
    localparam logic [CW-1:0] MOD_C = CW'(SEQ_COUNT);
    localparam logic [CW-1:0] WIN_MAX_C = CW'(SEQ_COUNT - 1);
    localparam logic [arqsw_pkg::CNT_W-1:0] MAX_C = arqsw_pkg::CNT_W'(arqsw_pkg::MAX_RESULTS);

    function automatic logic [SW-1:0] inc_seq(input logic [SW-1:0] v);
        logic [SW:0] w;
        w = {1'b0, v} + (SW+1)'(1);
        return (w == (SW+1)'(SEQ_COUNT)) ? '0 : w[SW-1:0];
    endfunction

    logic [SW-1:0]                      base_reg, base_next;
    logic [SW-1:0]                      next_reg, next_next;
    logic [arqsw_pkg::WIN_W-1:0]        win_reg, win_next;
    logic [SW-1:0]                      cur_reg, cur_next;
    logic [arqsw_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [arqsw_pkg::KIND_W-1:0]       kind_reg, kind_next;
    logic [arqsw_pkg::SEQ_FIELD_W-1:0]  oseq_reg, oseq_next;
    logic                               last_reg, last_next;

    logic [CW-1:0] ack_w;
    logic [SW-1:0] ack_s;
    logic [CW-1:0] outst;
    logic [CW-1:0] win_cap;
    logic          new_ok;
    logic [SW-1:0] step_seq;
    logic [arqsw_pkg::CNT_W-1:0] cnt_inc;

    always_comb begin
        ack_w = CW'(s_ack_seq);
        for (int i = 0; i < 4; i++) begin
            if (ack_w >= MOD_C) begin
                ack_w = ack_w - MOD_C;
            end
        end
        ack_s = ack_w[SW-1:0];
    end

    always_comb begin
        if (next_reg >= base_reg) begin
            outst = CW'(next_reg) - CW'(base_reg);
        end else begin
            outst = CW'(next_reg) + MOD_C - CW'(base_reg);
        end
        win_cap = (CW'(win_reg) > WIN_MAX_C) ? WIN_MAX_C : CW'(win_reg);
        new_ok  = outst < win_cap;
    end

    always_comb begin
        unique case (s_req_type)
            arqsw_pkg::REQ_NEW:     sts.produces = 1'b1;
            arqsw_pkg::REQ_ACK:     sts.produces = s_ack_error;
            arqsw_pkg::REQ_TIMEOUT: sts.produces = (base_reg != next_reg);
            arqsw_pkg::REQ_UNUSED:  sts.produces = 1'b0;
            default:                sts.produces = 1'b0;
        endcase
        sts.last = last_reg;
    end

    assign step_seq = inc_seq(cur_reg);
    assign cnt_inc  = cnt_reg + arqsw_pkg::CNT_W'(1);

    always_comb begin
        base_next = base_reg;
        next_next = next_reg;
        win_next  = win_reg;
        cur_next  = cur_reg;
        cnt_next  = cnt_reg;
        kind_next = kind_reg;
        oseq_next = oseq_reg;
        last_next = last_reg;
        if (cfg_write) begin
            win_next = cfg_window_size;
        end
        if (cmd.load) begin
            unique case (s_req_type)
                arqsw_pkg::REQ_NEW: begin
                    last_next = 1'b1;
                    if (new_ok) begin
                        kind_next = arqsw_pkg::KIND_SEND;
                        oseq_next = arqsw_pkg::SEQ_FIELD_W'(next_reg);
                        next_next = inc_seq(next_reg);
                    end else begin
                        kind_next = arqsw_pkg::KIND_REFUSED;
                        oseq_next = '0;
                    end
                end
                arqsw_pkg::REQ_ACK: begin
                    if (s_ack_error) begin
                        kind_next = arqsw_pkg::KIND_ERROR;
                        oseq_next = arqsw_pkg::SEQ_FIELD_W'(ack_s);
                        last_next = 1'b1;
                    end else begin
                        base_next = inc_seq(ack_s);
                    end
                end
                arqsw_pkg::REQ_TIMEOUT: begin
                    kind_next = arqsw_pkg::KIND_TIMEOUT;
                    oseq_next = arqsw_pkg::SEQ_FIELD_W'(base_reg);
                    cur_next  = base_reg;
                    cnt_next  = arqsw_pkg::CNT_W'(1);
                    last_next = (inc_seq(base_reg) == next_reg)
                                || (arqsw_pkg::CNT_W'(1) == MAX_C);
                end
                arqsw_pkg::REQ_UNUSED: begin
                    last_next = last_reg;
                end
                default: begin
                    last_next = last_reg;
                end
            endcase
        end else if (cmd.step) begin
            cur_next  = step_seq;
            cnt_next  = cnt_inc;
            oseq_next = arqsw_pkg::SEQ_FIELD_W'(step_seq);
            last_next = (inc_seq(step_seq) == next_reg) || (cnt_inc == MAX_C);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            next_reg <= '0;
            win_reg  <= arqsw_pkg::WINDOW_RESET;
            last_reg <= 1'b1;
        end else begin
            base_reg <= base_next;
            next_reg <= next_next;
            win_reg  <= win_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        cnt_reg  <= cnt_next;
        kind_reg <= kind_next;
        oseq_reg <= oseq_next;
    end

    assign m_kind = kind_reg;
    assign m_seq  = oseq_reg;
    assign m_last = last_reg;

endmodule
`default_nettype wire

>>> hdl/arq_sliding_window_sender.sv
// Top level of the sliding-window ARQ sender control block.
//
// The s_ channel takes one request per transfer: a new-frame request, an
// acknowledgement or a retransmit timeout tick. The m_ channel returns the
// results: a slot to send, a slot to resend, or a refusal, with m_last set on
// the final result of each request. A clean acknowledgement only moves the
// window base and returns nothing; a timeout returns one result per slot from
// the base up to the next number, at most seven.
// A request is taken in the idle state and its first result is valid in the
// cycle after it is taken. Each further timeout result is valid in the cycle
// after the previous transfer. A new request is taken only after the last
// result of the previous one has been transferred; a request with no result
// leaves the block idle. A stalled receiver holds the current result and the
// block waits. The window size register is written over the cfg_ channel; the
// user must write it only while idle; the block does not enforce this.
// Synchronous reset clears the base and next numbers, restores a window of
// four and drops m_valid.
`default_nettype none
module arq_sliding_window_sender #(
    parameter int SEQ_COUNT = arqsw_pkg::SEQ_COUNT_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [arqsw_pkg::WIN_W-1:0]         cfg_window_size,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [arqsw_pkg::REQ_W-1:0]         s_req_type,
    input  wire logic [arqsw_pkg::SEQ_FIELD_W-1:0]   s_ack_seq,
    input  wire logic                                s_ack_error,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [arqsw_pkg::KIND_W-1:0]             m_kind,
    output logic [arqsw_pkg::SEQ_FIELD_W-1:0]        m_seq,
    output logic                                     m_last
);

`include "assert_macros.svh"

    arqsw_pkg::cmd_t cmd;
    arqsw_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    arqsw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    arqsw_dpath #(
        .SEQ_COUNT (SEQ_COUNT)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_window_size (cfg_window_size),
        .s_req_type      (s_req_type),
        .s_ack_seq       (s_ack_seq),
        .s_ack_error     (s_ack_error),
        .cmd             (cmd),
        .sts             (sts),
        .m_kind          (m_kind),
        .m_seq           (m_seq),
        .m_last          (m_last)
    );

    `ASSERT_NEVER_BOTH(a_no_intake_while_out, m_valid, s_ready, "input taken while a result is pending")
    `ASSERT_CLK(a_last_ends_run, (m_valid && m_ready && m_last) |=> !m_valid, "result valid after the last transfer")
    `ASSERT_CLK(a_new_gives_result, (s_valid && s_ready && s_req_type == arqsw_pkg::REQ_NEW) |=> (m_valid && m_last), "new-frame request without a single result")
    `ASSERT_CLK(a_single_unless_timeout, (m_valid && m_kind != arqsw_pkg::KIND_TIMEOUT) |-> m_last, "non-timeout result not marked last")

endmodule
`default_nettype wire
